FILE: rtl/cbm_pkg.sv
// Shared types, register indexes and decode constants for the cartridge bank mapper.
// Used by every module of the mapper and by its checker; depends on nothing else.
`timescale 1ns / 1ps

package cbm_pkg;

   // Request word: command, bus address and written byte.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] address;
      logic [7:0]  data;
   } cbm_req_type;

   // Response word: translated address, interrupt level and mirroring select.
   typedef struct packed {
      logic [24:0] mapped_address;
      logic        irq;
      logic        mirror;
   } cbm_rsp_type;

   // Sixteen byte-wide registers, indexed by a 4-bit register number.
   typedef logic [15:0][7:0] cbm_regfile_type;

   // Status that follows from the word being retired this cycle.
   typedef struct packed {
      logic irq_next;
      logic mirror_next;
   } cbm_status_type;

   // Command codes.
   localparam logic [2:0] CMD_WR_EXT  = 3'd0;
   localparam logic [2:0] CMD_WR_PPU  = 3'd1;
   localparam logic [2:0] CMD_WR_BANK = 3'd2;
   localparam logic [2:0] CMD_TICK    = 3'd3;
   localparam logic [2:0] CMD_PRG     = 3'd4;
   localparam logic [2:0] CMD_CHR     = 3'd5;

   // CPU-side register indexes.
   localparam logic [3:0] CPU_OUTER    = 4'h0;
   localparam logic [3:0] CPU_LATCH    = 4'h1;
   localparam logic [3:0] CPU_BANK_CMD = 4'h5;
   localparam logic [3:0] CPU_MIRROR   = 4'h6;
   localparam logic [3:0] CPU_PRG0     = 4'h7;
   localparam logic [3:0] CPU_PRG1     = 4'h8;
   localparam logic [3:0] CPU_PRG2     = 4'h9;
   localparam logic [3:0] CPU_PRG_BASE = 4'ha;
   localparam logic [3:0] CPU_PRG_MODE = 4'hb;

   // PPU-side register indexes.
   localparam logic [3:0] PPU_CHR0      = 4'h6;
   localparam logic [3:0] PPU_CHR1      = 4'h7;
   localparam logic [3:0] PPU_CHR_OUTER = 4'h8;
   localparam logic [3:0] PPU_CHR_BASE  = 4'ha;
   localparam logic [3:0] PPU_CHR_FIRST = 4'h2;

   // Offsets with side effects in the extended window.
   localparam logic [3:0] EXT_LATCH   = 4'h1;
   localparam logic [3:0] EXT_RELOAD  = 4'h2;
   localparam logic [3:0] EXT_IRQ_OFF = 4'h3;
   localparam logic [3:0] EXT_IRQ_ON  = 4'h4;

   // Bank window decode: address bits 15:13 and 0.
   localparam logic [15:0] WIN_DECODE      = 16'he001;
   localparam logic [15:0] WIN_BANK_SELECT = 16'h8000;
   localparam logic [15:0] WIN_BANK_DATA   = 16'h8001;
   localparam logic [15:0] WIN_MIRROR      = 16'ha000;
   localparam logic [15:0] WIN_IRQ_LATCH   = 16'hc000;
   localparam logic [15:0] WIN_IRQ_RELOAD  = 16'hc001;
   localparam logic [15:0] WIN_IRQ_DISABLE = 16'he000;
   localparam logic [15:0] WIN_IRQ_ENABLE  = 16'he001;

   localparam logic [7:0] LATCH_MASK     = 8'hfe;
   localparam logic [7:0] BANK_CMD_KEEP  = 8'h38;
   localparam logic [7:0] BANK_CMD_TAKE  = 8'hc7;
   localparam logic [7:0] PRG_MASK_BASE  = 8'h3f;
   localparam logic [7:0] PRG_FIXED_BANK = 8'hfe;
   localparam logic [7:0] PRG_LAST_BANK  = 8'hff;
   localparam logic [2:0] PRG_MODE_FULL  = 3'd7;

   // Right shift applied to the pattern bank mask for each size code.
   function automatic logic [2:0] chr_shift(input logic [2:0] code);
      logic [2:0] sh;
      case (code)
         3'd1:    sh = 3'd1;
         3'd2:    sh = 3'd2;
         3'd4:    sh = 3'd3;
         3'd5:    sh = 3'd4;
         3'd6:    sh = 3'd5;
         default: sh = 3'd0;
      endcase
      return sh;
   endfunction

   // PPU-side register that a bank data write reaches for selectors below six.
   function automatic logic [3:0] ppu_dest(input logic [2:0] sel);
      logic [3:0] idx;
      case (sel)
         3'd0:    idx = 4'h6;
         3'd1:    idx = 4'h7;
         3'd2:    idx = 4'h2;
         3'd3:    idx = 4'h3;
         3'd4:    idx = 4'h4;
         default: idx = 4'h5;
      endcase
      return idx;
   endfunction

endpackage

FILE: rtl/cartridge_bank_mapper_with_irq.sv
// Top level of the cartridge bank mapper with scanline interrupt.
// Instantiates cbm_state and cbm_xlate; depends on cbm_pkg.
`timescale 1ns / 1ps
//
// Usage
// -----
// The request channel (req_valid, req_ready, req_word) carries one word per item:
// a register write in one of three windows, a scanline tick, or a program or
// pattern translation. The response channel (rsp_valid, rsp_ready, rsp_word)
// returns exactly one word per request, in order: the translated address (zero
// for anything but an in-range translation), the interrupt level and the
// mirroring select as they stand after that request.
// The csr port writes the program slot swap bit whenever csr_we is high.
// A request is captured in an input register and, once the output register can
// take a word, retired by one pass of combinational logic that also updates the
// register files and counter; its response sits in an output register. Throughput
// is one word per cycle without receiver stalls, set by that single retire stage.
// Reset clears all mapper registers, the counter, the interrupt state and both
// pipeline stages. When the receiver stalls, the response register holds its
// word, one further request waits in the input register, and req_ready drops.

module cartridge_bank_mapper_with_irq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cbm_pkg::cbm_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cbm_pkg::cbm_rsp_type rsp_word,
   input  logic                 csr_we,
   input  logic                 csr_wdata
);

   logic                     in_valid_ff;
   cbm_pkg::cbm_req_type     in_word_ff;
   logic                     out_valid_ff;
   cbm_pkg::cbm_rsp_type     out_word_ff, out_word_in;
   logic                     swap_ff;
   logic                     advance;
   cbm_pkg::cbm_regfile_type cpu_regs, ppu_regs;
   cbm_pkg::cbm_status_type  status;
   logic [24:0]              mapped;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            swap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   cbm_state u_state (
      .clock    (clock),
      .reset    (reset),
      .go       (advance),
      .word     (in_word_ff),
      .cpu_regs (cpu_regs),
      .ppu_regs (ppu_regs),
      .status   (status)
   );

   cbm_xlate u_xlate (
      .word           (in_word_ff),
      .cpu_regs       (cpu_regs),
      .ppu_regs       (ppu_regs),
      .swap_prg       (swap_ff),
      .mapped_address (mapped)
   );

   always_comb begin
      out_word_in.mapped_address = mapped;
      out_word_in.irq            = status.irq_next;
      out_word_in.mirror         = status.mirror_next;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

FILE: rtl/cbm_state.sv
// Register files, scanline counter and interrupt state of the bank mapper.
// Retires one request word per enabled cycle; depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_state (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  cbm_pkg::cbm_req_type     word,
   output cbm_pkg::cbm_regfile_type cpu_regs,
   output cbm_pkg::cbm_regfile_type ppu_regs,
   output cbm_pkg::cbm_status_type  status
);

   cbm_pkg::cbm_regfile_type cpu_ff;
   cbm_pkg::cbm_regfile_type ppu_ff;
   logic [7:0] count_ff, count_in;
   logic       reload_ff, reload_in;
   logic       enabled_ff, enabled_in;
   logic       pending_ff, pending_in;

   logic       cpu_we, ppu_we;
   logic [3:0] cpu_waddr, ppu_waddr;
   logic [7:0] cpu_wdata, ppu_wdata;
   logic [2:0] sel;

   assign sel = cpu_ff[cbm_pkg::CPU_BANK_CMD][2:0];

   always_comb begin
      cpu_we     = 1'b0;
      cpu_waddr  = word.address[3:0];
      cpu_wdata  = word.data;
      ppu_we     = 1'b0;
      ppu_waddr  = word.address[3:0];
      ppu_wdata  = word.data;
      count_in   = count_ff;
      reload_in  = reload_ff;
      enabled_in = enabled_ff;
      pending_in = pending_ff;
      if (go) begin
         case (word.cmd)
            cbm_pkg::CMD_WR_EXT: begin
               case (word.address[3:0])
                  cbm_pkg::EXT_LATCH: begin
                     cpu_we    = 1'b1;
                     cpu_wdata = word.data & cbm_pkg::LATCH_MASK;
                  end
                  cbm_pkg::EXT_RELOAD: begin
                     reload_in = 1'b1;
                  end
                  cbm_pkg::EXT_IRQ_OFF: begin
                     enabled_in = 1'b0;
                     pending_in = 1'b0;
                  end
                  cbm_pkg::EXT_IRQ_ON: begin
                     enabled_in = 1'b1;
                  end
                  default: begin
                     cpu_we = 1'b1;
                  end
               endcase
            end
            cbm_pkg::CMD_WR_PPU: begin
               ppu_we = 1'b1;
            end
            cbm_pkg::CMD_WR_BANK: begin
               case (word.address & cbm_pkg::WIN_DECODE)
                  cbm_pkg::WIN_BANK_SELECT: begin
                     cpu_we    = 1'b1;
                     cpu_waddr = cbm_pkg::CPU_BANK_CMD;
                     cpu_wdata = (cpu_ff[cbm_pkg::CPU_BANK_CMD] & cbm_pkg::BANK_CMD_KEEP)
                               | (word.data & cbm_pkg::BANK_CMD_TAKE);
                  end
                  cbm_pkg::WIN_BANK_DATA: begin
                     if (sel < 3'd6) begin
                        ppu_we    = 1'b1;
                        ppu_waddr = cbm_pkg::ppu_dest(sel);
                     end else begin
                        cpu_we    = 1'b1;
                        cpu_waddr = sel[0] ? cbm_pkg::CPU_PRG1 : cbm_pkg::CPU_PRG0;
                     end
                  end
                  cbm_pkg::WIN_MIRROR: begin
                     cpu_we    = 1'b1;
                     cpu_waddr = cbm_pkg::CPU_MIRROR;
                  end
                  cbm_pkg::WIN_IRQ_LATCH: begin
                     cpu_we    = 1'b1;
                     cpu_waddr = cbm_pkg::CPU_LATCH;
                     cpu_wdata = word.data & cbm_pkg::LATCH_MASK;
                  end
                  cbm_pkg::WIN_IRQ_RELOAD: begin
                     reload_in = 1'b1;
                  end
                  cbm_pkg::WIN_IRQ_DISABLE: begin
                     enabled_in = 1'b0;
                     pending_in = 1'b0;
                  end
                  cbm_pkg::WIN_IRQ_ENABLE: begin
                     enabled_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            cbm_pkg::CMD_TICK: begin
               if (count_ff == 8'd0 || reload_ff) begin
                  count_in  = cpu_ff[cbm_pkg::CPU_LATCH];
                  reload_in = 1'b0;
               end else begin
                  count_in = count_ff - 8'd1;
               end
               // Only a tick that takes a nonzero count to zero, by decrement or by reload, raises the interrupt.
               if (count_ff != 8'd0 && count_in == 8'd0 && enabled_ff) begin
                  pending_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_ff     <= '0;
         ppu_ff     <= '0;
         count_ff   <= '0;
         reload_ff  <= 1'b0;
         enabled_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         if (cpu_we) begin
            cpu_ff[cpu_waddr] <= cpu_wdata;
         end
         if (ppu_we) begin
            ppu_ff[ppu_waddr] <= ppu_wdata;
         end
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
      end
   end

   assign cpu_regs = cpu_ff;
   assign ppu_regs = ppu_ff;

   always_comb begin
      status.irq_next    = pending_in;
      status.mirror_next = ~((cpu_we && cpu_waddr == cbm_pkg::CPU_MIRROR) ?
                             cpu_wdata[0] : cpu_ff[cbm_pkg::CPU_MIRROR][0]);
   end

endmodule

FILE: rtl/cbm_xlate.sv
// Program and pattern address translation of the bank mapper.
// Purely combinational from the current register files; depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_xlate (
   input  cbm_pkg::cbm_req_type     word,
   input  cbm_pkg::cbm_regfile_type cpu_regs,
   input  cbm_pkg::cbm_regfile_type ppu_regs,
   input  logic                     swap_prg,
   output logic [24:0]              mapped_address
);

   logic [15:0] a;
   logic [2:0]  prg_mode;
   logic [7:0]  prg_mask, prg_bank;
   logic [11:0] prg_block;
   logic [1:0]  prg_slot;
   logic [24:0] prg_addr;

   logic [7:0]  chr_mask, chr_bank;
   logic [14:0] chr_block;
   logic [2:0]  chr_slot;
   logic [3:0]  chr_idx;
   logic [24:0] chr_addr;

   assign a = word.address;

   // Program space: four 8 KiB slots; bank command bit 6 trades slots 0 and 2 for A13 low.
   always_comb begin
      prg_mode  = cpu_regs[cbm_pkg::CPU_PRG_MODE][2:0];
      prg_mask  = (prg_mode == cbm_pkg::PRG_MODE_FULL) ? 8'hff
                                                       : (cbm_pkg::PRG_MASK_BASE >> prg_mode);
      prg_block = {cpu_regs[cbm_pkg::CPU_OUTER][7:4],
                   cpu_regs[cbm_pkg::CPU_PRG_BASE] & ~prg_mask};
      prg_slot  = {a[14] ^ (cpu_regs[cbm_pkg::CPU_BANK_CMD][6] & ~a[13]), a[13]};
      case (prg_slot)
         2'd0:    prg_bank = swap_prg ? cpu_regs[cbm_pkg::CPU_PRG1]
                                      : cpu_regs[cbm_pkg::CPU_PRG0];
         2'd1:    prg_bank = swap_prg ? cpu_regs[cbm_pkg::CPU_PRG0]
                                      : cpu_regs[cbm_pkg::CPU_PRG1];
         2'd2:    prg_bank = cpu_regs[cbm_pkg::CPU_PRG_MODE][6] ? cpu_regs[cbm_pkg::CPU_PRG2]
                                                                : cbm_pkg::PRG_FIXED_BANK;
         default: prg_bank = cbm_pkg::PRG_LAST_BANK;
      endcase
      prg_addr = a[15] ? {prg_block | {4'h0, prg_bank & prg_mask}, a[12:0]} : '0;
   end

   // Pattern space: eight 1 KiB slots, the first four paired from two registers.
   always_comb begin
      chr_mask  = 8'hff >> cbm_pkg::chr_shift(ppu_regs[cbm_pkg::PPU_CHR_BASE][2:0]);
      chr_block = {cpu_regs[cbm_pkg::CPU_OUTER][3:0],
                   ppu_regs[cbm_pkg::PPU_CHR_OUTER][6:4],
                   ppu_regs[cbm_pkg::PPU_CHR_BASE] & ~chr_mask};
      chr_slot  = {a[12] ^ cpu_regs[cbm_pkg::CPU_BANK_CMD][7], a[11:10]};
      chr_idx   = {1'b0, chr_slot} - 4'd4 + cbm_pkg::PPU_CHR_FIRST;
      case (chr_slot)
         3'd0:    chr_bank = ppu_regs[cbm_pkg::PPU_CHR0] & 8'hfe;
         3'd1:    chr_bank = ppu_regs[cbm_pkg::PPU_CHR0] | 8'h01;
         3'd2:    chr_bank = ppu_regs[cbm_pkg::PPU_CHR1] & 8'hfe;
         3'd3:    chr_bank = ppu_regs[cbm_pkg::PPU_CHR1] | 8'h01;
         default: chr_bank = ppu_regs[chr_idx];
      endcase
      chr_addr = (a[15:13] == 3'd0) ? {chr_block | {7'h00, chr_bank & chr_mask}, a[9:0]} : '0;
   end

   always_comb begin
      case (word.cmd)
         cbm_pkg::CMD_PRG: mapped_address = prg_addr;
         cbm_pkg::CMD_CHR: mapped_address = chr_addr;
         default:          mapped_address = '0;
      endcase
   end

endmodule

FILE: rtl/cbm_checker.sv
// Port-level checks for the cartridge bank mapper, bound to its top level.
// Depends on cbm_pkg and cartridge_bank_mapper_with_irq.
`timescale 1ns / 1ps

module cbm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input cbm_pkg::cbm_req_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cbm_pkg::cbm_rsp_type rsp_word,
   input logic                 csr_we
);

   // A stalled response word must not move.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // A waiting request word must stay offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("request word changed while waiting");

   // A response that appears from empty comes from a request taken earlier, via the input register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a matching request");

   // The swap bit is only written while no response is waiting.
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> !rsp_valid)
      else $error("swap bit written with a response outstanding");

   // Both stages are empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_checker (.*);
